FILE: rtl/core/prqm_pkg.sv
`default_nettype none
package prqm_pkg;

    localparam int ADDR_W = 48;
    localparam int REF_W  = 32;
    localparam int WIRE_W = 16;
    localparam int LEN_W  = 13;

    localparam logic [REF_W-1:0]  REF_MAX  = '1;
    localparam logic [WIRE_W-1:0] WIRE_MAX = '1;

    localparam logic [2:0] OP_HOLD     = 3'd0;
    localparam logic [2:0] OP_DROP     = 3'd1;
    localparam logic [2:0] OP_WIRE     = 3'd2;
    localparam logic [2:0] OP_UNWIRE   = 3'd3;
    localparam logic [2:0] OP_ACTIVATE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ADDR_W-1:0] phys_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              managed;
        logic [REF_W-1:0]  refs_after;
        logic [WIRE_W-1:0] wires_after;
        logic              in_active;
        logic              free_page;
        logic [LEN_W-1:0]  active_length;
    } rsp_t;

    typedef struct packed {
        logic [REF_W-1:0]  refs;
        logic [WIRE_W-1:0] wires;
        logic              queued;
    } entry_t;

    typedef struct packed {
        logic nxt;
        logic prv;
    } link_we_t;

endpackage
`default_nettype wire

FILE: rtl/core/page_refcount_wire_queue_manager.sv
`default_nettype none
// Page reference count, wire count and active queue keeper.
// Requests arrive on the s_ channel (valid/ready) as an operation and a
// physical address; one result per request leaves on the m_ channel.
// Managed range is set through the cfg_ write port (index 0 base, index 1
// limit); the user must write it only while the block is idle, as the block does not enforce this.
// Per-page counts and the queue links sit in two single-port-write RAMs
// with registered reads; each request runs decode with the RAM read,
// execute and two link write-back states (S_W1, S_W2), then the result is
// loaded into the output register; a new request is taken only after that.
// The sequence of dependent RAM accesses (read entry, patch the neighbour
// links one write per cycle) sets how long each request holds the block.
// After reset the block sweeps both RAMs, one entry a cycle, over all
// PAGE_COUNT entries with s_ready low; config writes are taken meanwhile.
// The result sits in an output register; if the receiver stalls, the block
// holds the next result until that register empties, accepting no further
// request in the meantime.
module page_refcount_wire_queue_manager #(
    parameter int PAGE_COUNT = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire prqm_pkg::req_t              s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output prqm_pkg::rsp_t                   m_data,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [prqm_pkg::ADDR_W-1:0] cfg_wdata
);
    import prqm_pkg::*;

    localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int LW = $clog2(PAGE_COUNT + 1);
    localparam int CW = $clog2(PAGE_COUNT + 1);
    localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_EXEC, S_W1, S_W2, S_DONE
    } state_t;

    state_t state_reg;
    logic [IW-1:0] clr_cnt_reg;

    logic [ADDR_W-1:0] base_reg, limit_reg;

    logic [2:0]        op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              mg_reg, zero_reg;
    logic [IW-1:0]     pg_reg;

    logic [LW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;

    logic          p1_en_reg, p2_en_reg;
    logic [IW-1:0] p1_addr_reg, p2_addr_reg;
    logic [LW-1:0] p1_val_reg, p2_val_reg;

    rsp_t res_reg;
    logic m_valid_reg;
    rsp_t m_data_reg;

    // address decode
    logic [ADDR_W-1:0] diff, idx;
    logic              mg_d;
    assign diff = addr_reg - base_reg;
    assign idx  = diff >> PAGE_SHIFT;
    assign mg_d = (limit_reg > base_reg) && (addr_reg >= base_reg) &&
                  (addr_reg < limit_reg) && (idx < ADDR_W'(PAGE_COUNT));

    // RAM ports
    logic          ent_we;
    logic [IW-1:0] ent_waddr, rd_addr;
    entry_t        ent_wdata, ent_rd;
    link_we_t      lnk_we;
    logic [IW-1:0] lnk_waddr;
    logic [LW-1:0] lnk_wnext, lnk_wprev, cur_next, cur_prev;

    prqm_entry_ram #(.DEPTH(PAGE_COUNT), .IW(IW)) u_entry (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(rd_addr), .rdata(ent_rd)
    );

    prqm_link_ram #(.DEPTH(PAGE_COUNT), .IW(IW), .LW(LW)) u_link (
        .aclk(aclk), .we(lnk_we), .waddr(lnk_waddr), .wnext(lnk_wnext),
        .wprev(lnk_wprev), .raddr(rd_addr), .rnext(cur_next), .rprev(cur_prev)
    );

    assign rd_addr = idx[IW-1:0];

    // execute: work out the new entry and queue state
    logic          p_ok, n_ok, tail_ok;
    logic [1:0]    status_x;
    entry_t        ent_x;
    logic          freed_x, unlink_x, append_x;
    logic [LW-1:0] head_x, tail_x;
    logic [CW-1:0] count_x;
    logic [CW+LEN_W-1:0] count_wide;

    assign p_ok    = cur_prev < NIL;
    assign n_ok    = cur_next < NIL;
    assign tail_ok = tail_reg < NIL;

    always_comb begin
        status_x = ST_OK;
        ent_x    = ent_rd;
        freed_x  = 1'b0;
        unlink_x = 1'b0;
        append_x = 1'b0;
        case (op_reg)
            OP_HOLD: begin
                if (zero_reg) begin
                    status_x = ST_INVALID;
                end else if (mg_reg && ent_rd.refs != REF_MAX) begin
                    ent_x.refs = ent_rd.refs + 1'b1;
                end
            end
            OP_DROP: begin
                if (zero_reg) begin
                    status_x = ST_INVALID;
                end else if (mg_reg) begin
                    if (ent_rd.refs == '0) begin
                        status_x = ST_ZERO;
                    end else begin
                        ent_x.refs = ent_rd.refs - 1'b1;
                        if (ent_rd.refs == REF_W'(1)) begin
                            freed_x  = 1'b1;
                            unlink_x = ent_rd.queued;
                        end
                    end
                end
            end
            OP_WIRE: begin
                if (!mg_reg) begin
                    status_x = ST_INVALID;
                end else if (ent_rd.wires != WIRE_MAX) begin
                    ent_x.wires = ent_rd.wires + 1'b1;
                    unlink_x    = (ent_rd.wires == '0) && ent_rd.queued;
                end
            end
            OP_UNWIRE: begin
                if (!mg_reg) begin
                    status_x = ST_INVALID;
                end else if (ent_rd.wires == '0) begin
                    status_x = ST_ZERO;
                end else begin
                    ent_x.wires = ent_rd.wires - 1'b1;
                    append_x    = (ent_rd.wires == WIRE_W'(1)) && !ent_rd.queued;
                end
            end
            OP_ACTIVATE: begin
                append_x = mg_reg && !ent_rd.queued && (ent_rd.wires == '0);
            end
            default: begin
            end
        endcase
        if (unlink_x) begin
            ent_x.queued = 1'b0;
        end else if (append_x) begin
            ent_x.queued = 1'b1;
        end

        head_x  = head_reg;
        tail_x  = tail_reg;
        count_x = count_reg;
        if (unlink_x) begin
            head_x = p_ok ? head_reg : cur_next;
            tail_x = n_ok ? tail_reg : cur_prev;
            if (!(head_x < NIL)) begin
                tail_x = NIL;
            end
            if (count_reg != '0) begin
                count_x = count_reg - 1'b1;
            end
        end else if (append_x) begin
            head_x = tail_ok ? head_reg : LW'(pg_reg);
            tail_x = LW'(pg_reg);
            if (count_reg < CW'(PAGE_COUNT)) begin
                count_x = count_reg + 1'b1;
            end
        end
    end

    assign count_wide = {{LEN_W{1'b0}}, count_x};

    // RAM write steering
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = pg_reg;
        ent_wdata = ent_x;
        lnk_we    = '0;
        lnk_waddr = pg_reg;
        lnk_wnext = NIL;
        lnk_wprev = NIL;
        unique case (state_reg)
            S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = clr_cnt_reg;
                ent_wdata = '0;
                lnk_we    = '{nxt: 1'b1, prv: 1'b1};
                lnk_waddr = clr_cnt_reg;
            end
            S_EXEC: begin
                ent_we    = mg_reg;
                lnk_we    = '{nxt: unlink_x || append_x, prv: unlink_x || append_x};
                lnk_wprev = append_x ? tail_reg : NIL;
            end
            S_W1: begin
                lnk_we.nxt = p1_en_reg;
                lnk_waddr  = p1_addr_reg;
                lnk_wnext  = p1_val_reg;
            end
            S_W2: begin
                lnk_we.prv = p2_en_reg;
                lnk_waddr  = p2_addr_reg;
                lnk_wprev  = p2_val_reg;
            end
            S_IDLE, S_DECODE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    logic out_free;
    logic out_load;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ((state_reg == S_W2) || (state_reg == S_DONE)) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            limit_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BASE:  base_reg  <= cfg_wdata;
                REG_LIMIT: limit_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IW'(PAGE_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_data.req_type;
                        addr_reg  <= s_data.phys_addr;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    mg_reg    <= mg_d;
                    zero_reg  <= (addr_reg == '0);
                    pg_reg    <= idx[IW-1:0];
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    head_reg  <= head_x;
                    tail_reg  <= tail_x;
                    count_reg <= count_x;
                    p1_en_reg   <= unlink_x ? p_ok : (append_x && tail_ok);
                    p1_addr_reg <= unlink_x ? cur_prev[IW-1:0] : tail_reg[IW-1:0];
                    p1_val_reg  <= unlink_x ? cur_next : LW'(pg_reg);
                    p2_en_reg   <= unlink_x && n_ok;
                    p2_addr_reg <= cur_next[IW-1:0];
                    p2_val_reg  <= cur_prev;
                    res_reg.status        <= status_x;
                    res_reg.managed       <= mg_reg;
                    res_reg.refs_after    <= mg_reg ? ent_x.refs : '0;
                    res_reg.wires_after   <= mg_reg ? ent_x.wires : '0;
                    res_reg.in_active     <= mg_reg && ent_x.queued;
                    res_reg.free_page     <= freed_x;
                    res_reg.active_length <= count_wide[LEN_W-1:0];
                    state_reg <= S_W1;
                end
                S_W1: begin
                    state_reg <= S_W2;
                end
                S_W2, S_DONE: begin
                    // hold the result until the output register frees up
                    if (out_load) begin
                        m_data_reg <= res_reg;
                        state_reg  <= S_IDLE;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

FILE: rtl/core/prqm_entry_ram.sv
`default_nettype none
module prqm_entry_ram #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [IW-1:0]    waddr,
    input  wire prqm_pkg::entry_t wdata,
    input  wire logic [IW-1:0]    raddr,
    output prqm_pkg::entry_t      rdata
);
    import prqm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

FILE: rtl/core/prqm_link_ram.sv
`default_nettype none
module prqm_link_ram #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12,
    parameter int LW    = 13
) (
    input  wire logic               aclk,
    input  wire prqm_pkg::link_we_t we,
    input  wire logic [IW-1:0]      waddr,
    input  wire logic [LW-1:0]      wnext,
    input  wire logic [LW-1:0]      wprev,
    input  wire logic [IW-1:0]      raddr,
    output logic [LW-1:0]           rnext,
    output logic [LW-1:0]           rprev
);
    import prqm_pkg::*;

    logic [LW-1:0] nxt_mem [DEPTH];
    logic [LW-1:0] prv_mem [DEPTH];
    logic [LW-1:0] rnext_reg;
    logic [LW-1:0] rprev_reg;

    // each field has its own write lane at the shared address
    always_ff @(posedge aclk) begin
        if (we.nxt) begin
            nxt_mem[waddr] <= wnext;
        end
        if (we.prv) begin
            prv_mem[waddr] <= wprev;
        end
        rnext_reg <= nxt_mem[raddr];
        rprev_reg <= prv_mem[raddr];
    end

    assign rnext = rnext_reg;
    assign rprev = rprev_reg;
endmodule
`default_nettype wire

FILE: verif/page_refcount_wire_queue_manager_tb.sv
`timescale 1ns / 1ps

module page_refcount_wire_queue_manager_tb;
    import prqm_pkg::*;

    localparam int  PAGES     = 4096;
    localparam int  PG_SHIFT  = 12;
    localparam int  NIL       = PAGES;
    localparam logic [2:0] OP_QUERY = 3'd5;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
    localparam longint CYCLE_LIMIT = 4000000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    req_t              s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rsp_t              m_data;
    logic              cfg_we = 1'b0;
    logic              cfg_index = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;

    page_refcount_wire_queue_manager u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // mirror of the page stores
    logic [REF_W-1:0]  page_refs [PAGES];
    logic [WIRE_W-1:0] page_wires[PAGES];
    int                link_next[PAGES];
    int                link_prev[PAGES];
    bit                on_queue [PAGES];
    int                q_head, q_tail, q_len;
    logic [ADDR_W-1:0] range_base, range_limit;

    rsp_t   pending_rsp[$];
    int     error_count = 0;
    longint cycle_count = 0;
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    int     hold_off_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // receiver: check each transfer, then decide ready for the next edge
    always @(posedge aclk) begin
        rsp_t want;
        if (m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), 0);
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status != want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.managed != want.managed)
                    report_mismatch("managed", m_data.managed, want.managed);
                if (m_data.refs_after != want.refs_after)
                    report_mismatch("refs_after", m_data.refs_after, want.refs_after);
                if (m_data.wires_after != want.wires_after)
                    report_mismatch("wires_after", m_data.wires_after, want.wires_after);
                if (m_data.in_active != want.in_active)
                    report_mismatch("in_active", m_data.in_active, want.in_active);
                if (m_data.free_page != want.free_page)
                    report_mismatch("free_page", m_data.free_page, want.free_page);
                if (m_data.active_length != want.active_length)
                    report_mismatch("active_length", m_data.active_length,
                                    want.active_length);
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic void clear_mirror();
        for (int i = 0; i < PAGES; i++) begin
            page_refs[i]  = '0;
            page_wires[i] = '0;
            link_next[i]  = NIL;
            link_prev[i]  = NIL;
            on_queue[i]   = 1'b0;
        end
        q_head = NIL;
        q_tail = NIL;
        q_len  = 0;
        range_base  = '0;
        range_limit = '0;
    endfunction

    function automatic void queue_push(int pg);
        link_next[pg] = NIL;
        link_prev[pg] = q_tail;
        if (q_tail < NIL) link_next[q_tail] = pg;
        else q_head = pg;
        q_tail = pg;
        if (q_len < PAGES) q_len++;
        on_queue[pg] = 1'b1;
    endfunction

    function automatic void queue_remove(int pg);
        int p, n;
        p = link_prev[pg];
        n = link_next[pg];
        if (p < NIL) link_next[p] = n;
        else q_head = n;
        if (n < NIL) link_prev[n] = p;
        else q_tail = p;
        if (q_head >= NIL) q_tail = NIL;
        link_next[pg] = NIL;
        link_prev[pg] = NIL;
        on_queue[pg]  = 1'b0;
        if (q_len > 0) q_len--;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t   o;
        bit     mg;
        int     pg;
        longint unsigned idx;
        mg = 1'b0;
        pg = 0;
        o  = '0;
        o.status = ST_OK;
        if (range_limit > range_base && r.phys_addr >= range_base
                && r.phys_addr < range_limit) begin
            idx = 64'(r.phys_addr - range_base) >> PG_SHIFT;
            if (idx < PAGES) begin
                mg = 1'b1;
                pg = int'(idx);
            end
        end
        case (r.req_type)
            OP_HOLD: begin
                if (r.phys_addr == 0) o.status = ST_INVALID;
                else if (mg && page_refs[pg] != REF_MAX) page_refs[pg]++;
            end
            OP_DROP: begin
                if (r.phys_addr == 0) begin
                    o.status = ST_INVALID;
                end else if (mg) begin
                    if (page_refs[pg] == 0) begin
                        o.status = ST_ZERO;
                    end else begin
                        page_refs[pg]--;
                        if (page_refs[pg] == 0) begin
                            if (on_queue[pg]) queue_remove(pg);
                            o.free_page = 1'b1;
                        end
                    end
                end
            end
            OP_WIRE: begin
                if (!mg) begin
                    o.status = ST_INVALID;
                end else if (page_wires[pg] != WIRE_MAX) begin
                    page_wires[pg]++;
                    if (page_wires[pg] == 1 && on_queue[pg]) queue_remove(pg);
                end
            end
            OP_UNWIRE: begin
                if (!mg) begin
                    o.status = ST_INVALID;
                end else if (page_wires[pg] == 0) begin
                    o.status = ST_ZERO;
                end else begin
                    page_wires[pg]--;
                    if (page_wires[pg] == 0 && !on_queue[pg]) queue_push(pg);
                end
            end
            OP_ACTIVATE: begin
                if (mg && !on_queue[pg] && page_wires[pg] == 0) queue_push(pg);
            end
            default: ;
        endcase
        o.managed       = mg;
        o.refs_after    = mg ? page_refs[pg] : '0;
        o.wires_after   = mg ? page_wires[pg] : '0;
        o.in_active     = mg && on_queue[pg];
        o.active_length = LEN_W'(q_len);
        return o;
    endfunction

    // called at a clock edge; returns at the edge of the transfer, or later if the sender then idles
    task automatic send_request(input logic [2:0] op, input logic [ADDR_W-1:0] addr);
        req_t r;
        r.req_type  = op;
        r.phys_addr = addr;
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        pending_rsp.push_back(apply_request(r));
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_BASE) range_base = val;
        else range_limit = val;
    endtask

    task automatic set_range(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] l);
        write_reg(REG_BASE, b);
        write_reg(REG_LIMIT, l);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(int pg);
        return range_base + (ADDR_W'(pg) << PG_SHIFT) + ADDR_W'($urandom_range(4095));
    endfunction

    task automatic test_directed_ops();
        set_range(48'h1000, 48'h1000 + (48'd8 << PG_SHIFT));
        send_request(OP_HOLD, '0);
        send_request(OP_DROP, '0);
        send_request(OP_WIRE, '0);
        send_request(OP_HOLD, ADDR_TOP);
        send_request(OP_DROP, ADDR_TOP);
        send_request(OP_DROP, page_addr(0));
        send_request(OP_UNWIRE, page_addr(0));
        send_request(OP_ACTIVATE, page_addr(0));
        send_request(OP_ACTIVATE, page_addr(1));
        send_request(OP_ACTIVATE, page_addr(2));
        send_request(OP_HOLD, page_addr(1));
        send_request(OP_HOLD, page_addr(1));
        send_request(OP_WIRE, page_addr(1));
        send_request(OP_ACTIVATE, page_addr(1));
        send_request(OP_UNWIRE, page_addr(1));
        send_request(OP_DROP, page_addr(1));
        send_request(OP_DROP, page_addr(1));
        send_request(OP_QUERY, page_addr(2));
        send_request(3'd6, page_addr(0));
        send_request(3'd7, page_addr(0));
        send_request(OP_ACTIVATE, range_limit);
        drain();
        // range spans the whole space: address zero is page 0, high addresses lie beyond the stores
        set_range('0, ADDR_TOP);
        send_request(OP_WIRE, '0);
        send_request(OP_UNWIRE, '0);
        send_request(OP_ACTIVATE, '0);
        send_request(OP_QUERY, '0);
        send_request(OP_HOLD, ADDR_TOP);
        drain();
    endtask

    // stack up wires on a queued page, then unwire past zero
    task automatic test_wire_counts();
        logic [ADDR_W-1:0] a;
        set_range(48'h0000_0040_0000, 48'h0000_0040_4000);
        a = page_addr(3);
        send_request(OP_ACTIVATE, a);
        for (int i = 0; i < 20; i++) send_request(OP_WIRE, a);
        for (int i = 0; i < 21; i++) send_request(OP_UNWIRE, a);
        drain();
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr(int span_pages);
        int sel;
        sel = $urandom_range(99);
        if (sel < 82) return page_addr($urandom_range(span_pages - 1));
        if (sel < 85) return '0;
        if (sel < 88) return range_base - 1;
        if (sel < 91) return range_limit;
        if (sel < 93) return ADDR_TOP;
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [2:0] pick_op();
        int sel;
        sel = $urandom_range(99);
        if (sel < 28) return OP_HOLD;
        if (sel < 50) return OP_DROP;
        if (sel < 62) return OP_WIRE;
        if (sel < 74) return OP_UNWIRE;
        if (sel < 90) return OP_ACTIVATE;
        if (sel < 96) return OP_QUERY;
        return 3'($urandom_range(7, 6));
    endfunction

    task automatic random_phase(input int n, input int span_pages);
        for (int i = 0; i < n; i++) send_request(pick_op(), pick_addr(span_pages));
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] b;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            b = ADDR_W'({$urandom, $urandom});
            case (ph)
                0: set_range(48'h2000, 48'h2000 + (48'd12 << PG_SHIFT));
                1: set_range(b & 48'h7FFF_FFFF_F000, (b & 48'h7FFF_FFFF_F000) + 48'h1_0000);
                2: set_range(ADDR_TOP - 48'h7FFF, ADDR_TOP);
                3: set_range(b | 48'h1, (b | 48'h1) + (48'd24 << PG_SHIFT));
                4: set_range(b, b);
                5: set_range(48'h5000, 48'h3000);
                6: set_range(~b & 48'h0FFF_FFFF_FFFF, (~b & 48'h0FFF_FFFF_FFFF) + 48'h3800);
                default: set_range(48'h10_0000, 48'h10_0000 + (48'd40 << PG_SHIFT));
            endcase
            random_phase(125, (ph == 2) ? 8 : 16);
            drain();
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps offering transfers
    task automatic test_back_pressure();
        set_range(48'h8000, 48'h8000 + (48'd6 << PG_SHIFT));
        hold_off_cycles = 300;
        random_phase(40, 6);
        drain();
    endtask

    initial begin
        clear_mirror();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        test_back_pressure();
        test_random_traffic();
        test_wire_counts();
        drain();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
